// ----- rtl/bbct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bandpass biquad coefficient table package
// Shared widths, action codes and default parameter values for the filter.
// ----------------------------------------------------------------------------
package bbct_pkg;

   // Fixed field widths of the request.
   localparam int ACTION_BITS = 2;
   localparam int INDEX_BITS  = 7;

   // Default sizes handed to the top level.
   localparam int TABLE_DEPTH_DEF    = 128;
   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int COEF_FRAC_BITS_DEF = 16;

   // Request kinds carried on the request tuser.
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_FILTER = 2'd0,
      ACT_LOAD   = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

endpackage : bbct_pkg
`default_nettype wire

// ----- rtl/bbct_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bbct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : bbct_ram
`default_nettype wire

// ----- rtl/bandpass_biquad_coef_table.sv -----
// A filter request passes the table read, the product stage and the
//   sum/round/saturate step into the output register, then leaves as a response.
// A filter or clear request reaches the products only once the previous output
//   has been stored; loads are taken every cycle when free.
// Only filter requests give a response. Reset clears the history, the pipeline
//   and the response; table entries stay undefined until loaded.
`default_nettype none
// ----------------------------------------------------------------------------
// Bandpass biquad with coefficient table
// Second-order bandpass IIR, y = a*(x - x2) + b*y1 - c*y2, with coefficient
// triples kept in a RAM that software loads entry by entry.
// ----------------------------------------------------------------------------
module bandpass_biquad_coef_table #(
   parameter int TABLE_DEPTH    = bbct_pkg::TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS    = bbct_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = bbct_pkg::COEF_FRAC_BITS_DEF,
   localparam int COEF_BITS     = COEF_FRAC_BITS + 2,
   localparam int REQ_RAW_BITS  = SAMPLE_BITS + bbct_pkg::INDEX_BITS + 3 * COEF_BITS,
   localparam int REQ_DATA_BITS = ((REQ_RAW_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: sample, coef_index, coef_a, coef_b, coef_c, zero fill
   input  wire logic [REQ_DATA_BITS-1:0]           req_tdata,
   // tuser: action
   input  wire logic [bbct_pkg::ACTION_BITS-1:0]   req_tuser,
   // Response channel.
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // tdata: filtered, zero fill
   output logic      [RSP_DATA_BITS-1:0]           rsp_tdata,
   // tuser: saturated
   output logic      [0:0]                         rsp_tuser
);

   import bbct_pkg::*;

   localparam int ADDR_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ENTRY_BITS = 3 * COEF_BITS;
   localparam int DIFF_BITS  = SAMPLE_BITS + 1;
   localparam int PROD_BITS  = COEF_BITS + DIFF_BITS;
   localparam int ACC_BITS   = PROD_BITS + 2;
   localparam int YW_BITS    = ACC_BITS - COEF_FRAC_BITS;
   localparam int IDX_OFS    = SAMPLE_BITS;
   localparam int A_OFS      = IDX_OFS + INDEX_BITS;
   localparam int B_OFS      = A_OFS + COEF_BITS;
   localparam int C_OFS      = B_OFS + COEF_BITS;

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
      ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
      {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Request field split.
   action_type                     req_action;
   logic signed [SAMPLE_BITS-1:0]  req_sample;
   logic [INDEX_BITS-1:0]          req_index;
   logic [INDEX_BITS+ADDR_BITS-1:0] req_index_wide;
   logic [ADDR_BITS-1:0]           req_addr;
   logic                           req_in_range;
   logic [ENTRY_BITS-1:0]          req_entry;

   assign req_action     = action_type'(req_tuser);
   assign req_sample     = $signed(req_tdata[SAMPLE_BITS-1:0]);
   assign req_index      = req_tdata[A_OFS-1:IDX_OFS];
   assign req_index_wide = {{ADDR_BITS{1'b0}}, req_index};
   assign req_addr       = req_index_wide[ADDR_BITS-1:0];
   assign req_in_range   = 32'(req_index) < 32'(TABLE_DEPTH);
   assign req_entry      = req_tdata[C_OFS+COEF_BITS-1:A_OFS];

   // Pipeline and history registers.
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_clear_ff, s1_clear_in;
   logic                          s1_in_range_ff, s1_in_range_in;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;
   logic                          s2_valid_ff, s2_valid_in;
   logic                          s2_clear_ff, s2_clear_in;
   logic signed [SAMPLE_BITS-1:0] s2_sample_ff, s2_sample_in;
   logic signed [PROD_BITS-1:0]   prod_a_ff, prod_a_in;
   logic signed [PROD_BITS-1:0]   prod_b_ff, prod_b_in;
   logic signed [PROD_BITS-1:0]   prod_c_ff, prod_c_in;
   logic signed [SAMPLE_BITS-1:0] in_hist_1_ff, in_hist_1_in;
   logic signed [SAMPLE_BITS-1:0] in_hist_2_ff, in_hist_2_in;
   logic signed [SAMPLE_BITS-1:0] out_hist_1_ff, out_hist_1_in;
   logic signed [SAMPLE_BITS-1:0] out_hist_2_ff, out_hist_2_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_ff, rsp_filtered_in;
   logic                          rsp_sat_ff, rsp_sat_in;

   // Handshake and stage movement.
   logic req_accept;
   logic req_enter;
   logic s1_adv;
   logic s2_done;

   assign s1_adv     = s1_valid_ff && !s2_valid_ff;
   assign s2_done    = s2_valid_ff && (s2_clear_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;
   assign req_enter  = req_accept &&
                       (req_action == ACT_FILTER || req_action == ACT_CLEAR);

   // Coefficient table: in-range loads write on acceptance, filter requests read.
   logic [ENTRY_BITS-1:0] ram_rd_data;

   bbct_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (req_accept && req_action == ACT_LOAD && req_in_range),
      .wr_addr (req_addr),
      .wr_data (req_entry),
      .rd_en   (req_accept && req_action == ACT_FILTER),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // Coefficients of the entry in stage one; an index past the table gives zero.
   logic signed [COEF_BITS-1:0] coef_a;
   logic signed [COEF_BITS-1:0] coef_b;
   logic signed [COEF_BITS-1:0] coef_c;
   logic signed [DIFF_BITS-1:0] in_diff;

   assign coef_a  = s1_in_range_ff ? $signed(ram_rd_data[COEF_BITS-1:0]) : '0;
   assign coef_b  = s1_in_range_ff ? $signed(ram_rd_data[2*COEF_BITS-1:COEF_BITS]) : '0;
   assign coef_c  = s1_in_range_ff ? $signed(ram_rd_data[3*COEF_BITS-1:2*COEF_BITS]) : '0;
   assign in_diff = DIFF_BITS'(s1_sample_ff) - DIFF_BITS'(in_hist_2_ff);

   // Sum, round half up and saturate in stage two.
   logic signed [ACC_BITS-1:0] acc_sum;
   logic signed [YW_BITS-1:0]  y_wide;
   logic [YW_BITS-SAMPLE_BITS:0] y_top;
   logic                       y_fits;
   logic signed [SAMPLE_BITS-1:0] y_clamped;

   always_comb begin
      acc_sum = ACC_BITS'(prod_a_ff) + ACC_BITS'(prod_b_ff) - ACC_BITS'(prod_c_ff)
                + ROUND_HALF;
      y_wide  = $signed(acc_sum[ACC_BITS-1:COEF_FRAC_BITS]);
      y_top   = y_wide[YW_BITS-1:SAMPLE_BITS-1];
      y_fits  = (&y_top) || !(|y_top);
      if (y_fits) begin
         y_clamped = y_wide[SAMPLE_BITS-1:0];
      end else if (y_wide[YW_BITS-1]) begin
         y_clamped = SAMPLE_MIN;
      end else begin
         y_clamped = SAMPLE_MAX;
      end
   end

   // Next-state logic of stage one.
   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_clear_in    = s1_clear_ff;
      s1_in_range_in = s1_in_range_ff;
      s1_sample_in   = s1_sample_ff;
      if (req_enter) begin
         s1_valid_in    = 1'b1;
         s1_clear_in    = (req_action == ACT_CLEAR);
         s1_in_range_in = req_in_range;
         s1_sample_in   = req_sample;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Next-state logic of stage two: products use the settled history.
   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_clear_in  = s2_clear_ff;
      s2_sample_in = s2_sample_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      prod_c_in    = prod_c_ff;
      if (s1_adv) begin
         s2_valid_in  = 1'b1;
         s2_clear_in  = s1_clear_ff;
         s2_sample_in = s1_sample_ff;
         prod_a_in    = PROD_BITS'(coef_a) * PROD_BITS'(in_diff);
         prod_b_in    = PROD_BITS'(coef_b) * PROD_BITS'(out_hist_1_ff);
         prod_c_in    = PROD_BITS'(coef_c) * PROD_BITS'(out_hist_2_ff);
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
      end
   end

   // History update when stage two retires a request.
   always_comb begin
      in_hist_1_in  = in_hist_1_ff;
      in_hist_2_in  = in_hist_2_ff;
      out_hist_1_in = out_hist_1_ff;
      out_hist_2_in = out_hist_2_ff;
      if (s2_done) begin
         if (s2_clear_ff) begin
            in_hist_1_in  = '0;
            in_hist_2_in  = '0;
            out_hist_1_in = '0;
            out_hist_2_in = '0;
         end else begin
            in_hist_1_in  = s2_sample_ff;
            in_hist_2_in  = in_hist_1_ff;
            out_hist_1_in = y_clamped;
            out_hist_2_in = out_hist_1_ff;
         end
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_filtered_in = rsp_filtered_ff;
      rsp_sat_in      = rsp_sat_ff;
      if (s2_done && !s2_clear_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_filtered_in = y_clamped;
         rsp_sat_in      = !y_fits;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and history registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         in_hist_1_ff  <= '0;
         in_hist_2_ff  <= '0;
         out_hist_1_ff <= '0;
         out_hist_2_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         in_hist_1_ff  <= in_hist_1_in;
         in_hist_2_ff  <= in_hist_2_in;
         out_hist_1_ff <= out_hist_1_in;
         out_hist_2_ff <= out_hist_2_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_clear_ff     <= s1_clear_in;
      s1_in_range_ff  <= s1_in_range_in;
      s1_sample_ff    <= s1_sample_in;
      s2_clear_ff     <= s2_clear_in;
      s2_sample_ff    <= s2_sample_in;
      prod_a_ff       <= prod_a_in;
      prod_b_ff       <= prod_b_in;
      prod_c_ff       <= prod_c_in;
      rsp_filtered_ff <= rsp_filtered_in;
      rsp_sat_ff      <= rsp_sat_in;
   end

   // Output ports.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'($unsigned(rsp_filtered_ff));
   assign rsp_tuser  = rsp_sat_ff;

   // A retired filter request always produces a response next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (s2_done && !s2_clear_ff) |=> rsp_valid_ff)
      else $error("filter request retired without a response");

   // Products are never taken while an older request still owns the history.
   assert property (@(posedge clock) disable iff (reset)
      s1_adv |-> !s2_valid_ff)
      else $error("stage one advanced over a pending history update");

   // A retired clear leaves the whole history at zero.
   assert property (@(posedge clock) disable iff (reset)
      (s2_done && s2_clear_ff) |=> (in_hist_1_ff == '0 && in_hist_2_ff == '0 &&
                                    out_hist_1_ff == '0 && out_hist_2_ff == '0))
      else $error("history not cleared");

   // A flagged response carries one of the range limits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         (rsp_filtered_ff == SAMPLE_MAX || rsp_filtered_ff == SAMPLE_MIN))
      else $error("saturation flag without a clipped value");

endmodule : bandpass_biquad_coef_table
`default_nettype wire
